>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros: concurrent assertion helpers
// implication checks that compile away when NO_ASSERTIONS is set
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

>>> rtl/vrn_pkg.sv
// ---------------------------------------------------------------------------
// vrn_pkg: shared types and constants
// widths, request codes, atan table and saturation helpers
// ---------------------------------------------------------------------------
`default_nettype none

package vrn_pkg;

  localparam int DEF_CORDIC_STAGES = 16;
  localparam int DEF_FRACTION_BITS = 16;
  localparam int GUARD_BITS = 8;
  localparam int CW = 44;   // cordic datapath width
  localparam int DW = 44;   // divisor width
  localparam int QB = 36;   // quotient bits
  localparam logic [31:0] INV_GAIN = 32'd2608131496;

  localparam logic [2:0] ACT_ROTATE = 3'd0;
  localparam logic [2:0] ACT_POLAR  = 3'd1;
  localparam logic [2:0] ACT_LENGTH = 3'd2;
  localparam logic [2:0] ACT_NORM   = 3'd3;
  localparam logic [2:0] ACT_CLAMP  = 3'd4;
  localparam logic [2:0] ACT_SETLEN = 3'd5;
  localparam logic [2:0] ACT_POS90  = 3'd6;
  localparam logic [2:0] ACT_NEG90  = 3'd7;

  typedef struct packed {
    logic vld;
    logic [2:0] action;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [30:0] len;
    logic zero;
  } item_t;

  typedef struct packed {
    logic signed [CW-1:0] xv;
    logic signed [CW-1:0] yv;
    logic [31:0] z;
    logic vect;
  } cvec_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QB-1:0] low;
    logic [QB-1:0] q;
  } div_t;

  typedef struct packed {
    logic vld;
    logic [2:0] action;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [30:0] len;
    logic zero;
    logic [31:0] rx;
    logic [31:0] ry;
    logic [30:0] len_o;
    logic [15:0] ang_o;
    logic dact;
    logic ovfx;
    logic ovfy;
    logic [DW-1:0] den;
  } res_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  // apply sign to a magnitude and clamp to 32-bit signed range
  function automatic logic [31:0] sat_mag(input logic neg, input logic [CW-1:0] m);
    logic [31:0] r;
    if (neg) begin
      if (m >= CW'(33'h0_8000_0000)) r = 32'h8000_0000;
      else r = ~m[31:0] + 32'd1;
    end else begin
      if (m > CW'(32'h7FFF_FFFF)) r = 32'h7FFF_FFFF;
      else r = m[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] neg_sat(input logic [31:0] v);
    logic [31:0] r;
    if (v == 32'h8000_0000) r = 32'h7FFF_FFFF;
    else r = ~v + 32'd1;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/vrn_cordic_stage.sv
// ---------------------------------------------------------------------------
// vrn_cordic_stage: one registered cordic iteration
// rotation mode steers by angle sign, vectoring mode by y sign
// ---------------------------------------------------------------------------
`default_nettype none

module vrn_cordic_stage import vrn_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic  clk,
  input  logic  en,
  input  cvec_t din,
  output cvec_t dout
);

  localparam logic [31:0] ATAN = atan_entry(5'(STAGE));

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic up;
  cvec_t dout_next;

  always_comb begin
    dx = din.yv >>> STAGE;
    dy = din.xv >>> STAGE;
    up = din.vect ? !din.yv[CW-1] : din.z[31];
    dout_next.vect = din.vect;
    if (up) begin
      dout_next.xv = din.xv + dx;
      dout_next.yv = din.yv - dy;
      dout_next.z  = din.z + ATAN;
    end else begin
      dout_next.xv = din.xv - dx;
      dout_next.yv = din.yv + dy;
      dout_next.z  = din.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) dout <= dout_next;
  end

endmodule

`default_nettype wire

>>> rtl/vrn_div_stage.sv
// ---------------------------------------------------------------------------
// vrn_div_stage: one restoring division step for both components
// brings down one numerator bit and produces one quotient bit
// ---------------------------------------------------------------------------
`default_nettype none

module vrn_div_stage import vrn_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] den,
  input  div_t          din_x,
  input  div_t          din_y,
  output div_t          dout_x,
  output div_t          dout_y
);

  function automatic div_t div_step(input div_t d, input logic [DW-1:0] dv);
    logic [DW:0] t;
    logic ge;
    div_t r;
    t = {d.rem, d.low[QB-1]};
    ge = (t >= {1'b0, dv});
    r.rem = ge ? DW'(t - {1'b0, dv}) : t[DW-1:0];
    r.low = {d.low[QB-2:0], 1'b0};
    r.q = {d.q[QB-2:0], ge};
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      dout_x <= div_step(din_x, den);
      dout_y <= div_step(din_y, den);
    end
  end

endmodule

`default_nettype wire

>>> rtl/vector2d_rotate_normalize_unit.sv
// ---------------------------------------------------------------------------
// vector2d_rotate_normalize_unit: pipelined 2d vector unit
// rotate, polar, length/angle, normalize, clamp, set length, +-90 degrees
// ---------------------------------------------------------------------------
// Fully pipelined: one request is taken every cycle unless the output
// stalls, and each request gives one result. The depth is set by the
// unrolled cordic iterations and the 36 restoring division steps that scale
// both components for normalize, clamp and set length. When the output is
// not taken the whole pipe holds, so nothing is dropped or repeated.
`default_nettype none
`include "assert_macros.svh"

module vector2d_rotate_normalize_unit import vrn_pkg::*; #(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // x_in[31:0], y_in[63:32], angle_in[79:64], length_in[110:80], zero pad[111]
  input  logic [111:0] s_axis_tdata,
  // action[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // x_out[31:0], y_out[63:32], length_out[94:64], angle_out[110:95], zero pad[111]
  output logic [111:0] m_axis_tdata
);

  localparam int MW = (FRACTION_BITS + GUARD_BITS + 1 > 31) ?
                      FRACTION_BITS + GUARD_BITS + 1 : 31;
  localparam int NW = 32 + MW + 1;
  localparam int PW = CW - 16 + 32;

  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // input decode and quadrant fold
  logic signed [31:0] in_x, in_y;
  logic [15:0] in_ang;
  logic [30:0] in_len;
  logic [2:0] in_act;
  logic in_vect;
  logic signed [CW-1:0] bx, by;
  cvec_t c0_next;
  item_t m0_next;

  always_comb begin
    in_x = s_axis_tdata[31:0];
    in_y = s_axis_tdata[63:32];
    in_ang = s_axis_tdata[79:64];
    in_len = s_axis_tdata[110:80];
    in_act = s_axis_tuser;
    in_vect = (in_act == ACT_LENGTH) || (in_act == ACT_NORM) ||
              (in_act == ACT_CLAMP) || (in_act == ACT_SETLEN);
    if (in_act == ACT_POLAR) begin
      bx = $signed(CW'(in_len)) <<< GUARD_BITS;
      by = '0;
    end else begin
      bx = CW'(in_x) <<< GUARD_BITS;
      by = CW'(in_y) <<< GUARD_BITS;
    end
    c0_next.vect = in_vect;
    c0_next.xv = bx;
    c0_next.yv = by;
    c0_next.z = {in_ang, 16'h0000};
    if (in_vect) begin
      c0_next.z = '0;
      if (bx[CW-1]) begin
        c0_next.xv = -bx;
        c0_next.yv = -by;
        c0_next.z = 32'h8000_0000;
      end
    end else if ((c0_next.z > 32'h4000_0000) && (c0_next.z < 32'hC000_0000)) begin
      c0_next.xv = -bx;
      c0_next.yv = -by;
      c0_next.z = c0_next.z - 32'h8000_0000;
    end
    m0_next.vld = s_axis_tvalid;
    m0_next.action = in_act;
    m0_next.x = in_x;
    m0_next.y = in_y;
    m0_next.len = in_len;
    m0_next.zero = (in_x == 32'sd0) && (in_y == 32'sd0);
  end

  cvec_t cv [0:CORDIC_STAGES];
  item_t cm [0:CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (rst) cm[0].vld <= 1'b0;
    else if (adv) begin
      cm[0] <= m0_next;
      cv[0] <= c0_next;
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    vrn_cordic_stage #(.STAGE(k)) u_stage (
      .clk  (clk),
      .en   (adv),
      .din  (cv[k]),
      .dout (cv[k+1])
    );
    always_ff @(posedge clk) begin
      if (rst) cm[k+1].vld <= 1'b0;
      else if (adv) cm[k+1] <= cm[k];
    end
  end

  // gain correction partial products
  item_t g1m;
  logic [PW-1:0] ph_x, ph_y;
  logic [47:0] pl_x, pl_y;
  logic negx1, negy1, xpos1, vect1;
  logic [31:0] z1;
  logic [CW-1:0] mag_x, mag_y;

  always_comb begin
    mag_x = cv[CORDIC_STAGES].xv[CW-1] ? CW'(-cv[CORDIC_STAGES].xv) : cv[CORDIC_STAGES].xv;
    mag_y = cv[CORDIC_STAGES].yv[CW-1] ? CW'(-cv[CORDIC_STAGES].yv) : cv[CORDIC_STAGES].yv;
  end

  always_ff @(posedge clk) begin
    if (rst) g1m.vld <= 1'b0;
    else if (adv) begin
      g1m <= cm[CORDIC_STAGES];
      ph_x <= PW'(mag_x[CW-1:16]) * PW'(INV_GAIN);
      ph_y <= PW'(mag_y[CW-1:16]) * PW'(INV_GAIN);
      pl_x <= 48'(mag_x[15:0]) * 48'(INV_GAIN);
      pl_y <= 48'(mag_y[15:0]) * 48'(INV_GAIN);
      negx1 <= cv[CORDIC_STAGES].xv[CW-1];
      negy1 <= cv[CORDIC_STAGES].yv[CW-1];
      xpos1 <= !cv[CORDIC_STAGES].xv[CW-1] && (cv[CORDIC_STAGES].xv != '0);
      vect1 <= cv[CORDIC_STAGES].vect;
      z1 <= cv[CORDIC_STAGES].z;
    end
  end

  // rounding, length, angle and divider setup
  logic [CW-1:0] mg_x, mg_y, lg, lr;
  logic [CW:0] rnd_x, rnd_y, rnd_l;
  logic [31:0] z_rnd;
  logic [MW-1:0] one_v;
  res_t d0_next;
  logic [31:0] magc_x, magc_y;
  logic [MW-1:0] mul_next;

  always_comb begin
    mg_x = CW'((ph_x + PW'(pl_x >> 16)) >> 16);
    mg_y = CW'((ph_y + PW'(pl_y >> 16)) >> 16);
    rnd_x = ({1'b0, mg_x} + (CW+1)'(1 << (GUARD_BITS - 1))) >> GUARD_BITS;
    rnd_y = ({1'b0, mg_y} + (CW+1)'(1 << (GUARD_BITS - 1))) >> GUARD_BITS;
    lg = (vect1 && xpos1 && !g1m.zero) ? mg_x : '0;
    rnd_l = ({1'b0, lg} + (CW+1)'(1 << (GUARD_BITS - 1))) >> GUARD_BITS;
    lr = rnd_l[CW-1:0];
    z_rnd = z1 + 32'h0000_8000;
    one_v = MW'(1) << (FRACTION_BITS + GUARD_BITS);
    d0_next.vld = g1m.vld;
    d0_next.action = g1m.action;
    d0_next.x = g1m.x;
    d0_next.y = g1m.y;
    d0_next.len = g1m.len;
    d0_next.zero = g1m.zero;
    d0_next.rx = sat_mag(negx1, rnd_x[CW-1:0]);
    d0_next.ry = sat_mag(negy1, rnd_y[CW-1:0]);
    d0_next.len_o = (lr > CW'(31'h7FFF_FFFF)) ? 31'h7FFF_FFFF : lr[30:0];
    d0_next.ang_o = g1m.zero ? 16'h0000 : z_rnd[31:16];
    d0_next.dact = !g1m.zero &&
                   (((g1m.action == ACT_NORM) && (lg != '0)) ||
                    ((g1m.action == ACT_CLAMP) && (lr > CW'(g1m.len))) ||
                    ((g1m.action == ACT_SETLEN) && (lr != '0)));
    d0_next.ovfx = 1'b0;
    d0_next.ovfy = 1'b0;
    d0_next.den = (g1m.action == ACT_NORM) ? DW'(lg) : DW'(lr);
    magc_x = g1m.x[31] ? (~g1m.x + 32'd1) : g1m.x;
    magc_y = g1m.y[31] ? (~g1m.y + 32'd1) : g1m.y;
    mul_next = (g1m.action == ACT_NORM) ? one_v : MW'(g1m.len);
  end

  res_t d0m, d1m;
  logic [31:0] magx0, magy0;
  logic [MW-1:0] mul0;
  logic [NW-1:0] numx1, numy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      d0m.vld <= 1'b0;
      d1m.vld <= 1'b0;
    end else if (adv) begin
      d0m <= d0_next;
      magx0 <= magc_x;
      magy0 <= magc_y;
      mul0 <= mul_next;
      d1m <= d0m;
      numx1 <= NW'(magx0) * NW'(mul0);
      numy1 <= NW'(magy0) * NW'(mul0);
    end
  end

  // rounding offset and quotient range check
  logic [NW-1:0] nx, ny;
  div_t dvx0, dvy0;
  res_t dm0_next;

  always_comb begin
    nx = numx1 + NW'(d1m.den >> 1);
    ny = numy1 + NW'(d1m.den >> 1);
    dm0_next = d1m;
    dm0_next.ovfx = (nx >> QB) >= NW'(d1m.den);
    dm0_next.ovfy = (ny >> QB) >= NW'(d1m.den);
    dvx0.rem = DW'(nx >> QB);
    dvx0.low = nx[QB-1:0];
    dvx0.q = '0;
    dvy0.rem = DW'(ny >> QB);
    dvy0.low = ny[QB-1:0];
    dvy0.q = '0;
  end

  div_t dvx [0:QB];
  div_t dvy [0:QB];
  res_t dm [0:QB];

  always_ff @(posedge clk) begin
    if (rst) dm[0].vld <= 1'b0;
    else if (adv) begin
      dm[0] <= dm0_next;
      dvx[0] <= dvx0;
      dvy[0] <= dvy0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    vrn_div_stage u_step (
      .clk    (clk),
      .en     (adv),
      .den    (dm[k].den),
      .din_x  (dvx[k]),
      .din_y  (dvy[k]),
      .dout_x (dvx[k+1]),
      .dout_y (dvy[k+1])
    );
    always_ff @(posedge clk) begin
      if (rst) dm[k+1].vld <= 1'b0;
      else if (adv) dm[k+1] <= dm[k];
    end
  end

  // result select
  res_t fm;
  logic [31:0] qx, qy, xo_next, yo_next;
  logic [30:0] lo_next;
  logic [15:0] ao_next;

  always_comb begin
    fm = dm[QB];
    qx = sat_mag(fm.x[31], fm.ovfx ? '1 : CW'(dvx[QB].q));
    qy = sat_mag(fm.y[31], fm.ovfy ? '1 : CW'(dvy[QB].q));
    lo_next = '0;
    ao_next = '0;
    xo_next = '0;
    yo_next = '0;
    case (fm.action) inside
      ACT_ROTATE, ACT_POLAR: begin
        xo_next = fm.rx;
        yo_next = fm.ry;
      end
      ACT_LENGTH: begin
        lo_next = fm.len_o;
        ao_next = fm.ang_o;
      end
      ACT_NORM: begin
        if (fm.dact) begin
          xo_next = qx;
          yo_next = qy;
        end
      end
      ACT_CLAMP: begin
        xo_next = fm.dact ? qx : fm.x;
        yo_next = fm.dact ? qy : fm.y;
      end
      ACT_SETLEN: begin
        xo_next = fm.dact ? qx : 32'(fm.len);
        yo_next = fm.dact ? qy : 32'd0;
      end
      ACT_POS90: begin
        xo_next = neg_sat(fm.y);
        yo_next = fm.x;
      end
      default: begin
        xo_next = fm.y;
        yo_next = neg_sat(fm.x);
      end
    endcase
  end

  logic out_vld;
  logic [2:0] out_act;
  logic [31:0] x_o, y_o;
  logic [30:0] len_o;
  logic [15:0] ang_o;

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (adv) begin
      out_vld <= fm.vld;
      out_act <= fm.action;
      x_o <= xo_next;
      y_o <= yo_next;
      len_o <= lo_next;
      ang_o <= ao_next;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata = {1'b0, ang_o, len_o, y_o, x_o};

  `ASSERT_IMPLY(a_len_no_xy, clk, rst, out_vld && (out_act == ACT_LENGTH), (x_o == '0) && (y_o == '0))
  `ASSERT_IMPLY(a_xy_no_len, clk, rst, out_vld && (out_act != ACT_LENGTH), (len_o == '0) && (ang_o == '0))
  `ASSERT_IMPLY(a_div_den, clk, rst, dm[0].vld && dm[0].dact, dm[0].den != '0)

endmodule

`default_nettype wire
